// File: rtl/core/sgmd_pkg.sv
// Shared constants, types and tables for the Sobel gradient block.
package sgmd_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int MAX_HEIGHT  = 4096;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = 12;
  localparam int WREG_W      = 12;
  localparam int HREG_W      = 13;
  localparam int FILL_W      = COL_W + 1;
  localparam int LINE_W      = 16;
  localparam int GRAD_W      = 11;
  localparam int MAG_W       = 15;
  localparam int DIR_W       = 15;
  localparam int CX_W        = 30;   // CORDIC x/y datapath, Q16 operands
  localparam int CZ_W        = 21;   // CORDIC angle accumulator, Q16
  localparam int SQ_W        = 31;   // square root operand
  localparam int STEP_W      = 4;
  localparam int ADDR_W      = 3;

  localparam logic [STEP_W-1:0] LAST_STEP = 4'd15;

  localparam logic [WREG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [HREG_W-1:0] HEIGHT_RESET = 13'd480;

  localparam logic signed [CZ_W-1:0] PI_Q16    = 21'sd205887;
  localparam logic signed [16:0]     DIR_LIMIT = 17'sd12868;

  // Register index, taken from paddr bit 2
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CALC,
    ST_HOLD
  } state_e;

  // atan(2^-i) in Q16
  function automatic logic [16:0] atan_q16(input logic [STEP_W-1:0] i);
    logic [16:0] a;
    case (i)
      4'd0:    a = 17'd51472;
      4'd1:    a = 17'd30386;
      4'd2:    a = 17'd16055;
      4'd3:    a = 17'd8150;
      4'd4:    a = 17'd4091;
      4'd5:    a = 17'd2047;
      4'd6:    a = 17'd1024;
      4'd7:    a = 17'd512;
      4'd8:    a = 17'd256;
      4'd9:    a = 17'd128;
      4'd10:   a = 17'd64;
      4'd11:   a = 17'd32;
      4'd12:   a = 17'd16;
      4'd13:   a = 17'd8;
      4'd14:   a = 17'd4;
      default: a = 17'd2;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/core/sobel_gradient_magnitude_direction_top.sv
// Top level: APB registers, line store, 3x3 window, control and output stage.
//
// Sobel 3x3 edge detector. Pixels enter on the s_axis channel in raster
// order, one 8-bit pixel per transfer. For every interior window centre a
// result leaves on m_axis: Gx, Gy, magnitude (Q11.4), direction (Q3.12 rad)
// and the centre coordinates; tlast marks the last result of a frame.
// Border centres produce no output transfer.
// Throughput: a new pixel is taken only after the last one has been handled. A
// pixel that yields no result passes transfer, line store read and window
// load; one that yields a result also passes engine start, 16 iterations of
// the shared CORDIC / square root unit and handoff. The 16-step iterative
// unit sets the rate. Output valid comes from the output register.
// The output register decouples the sides: a new pixel is taken while a
// result waits; if the receiver stalls and a second result is finished,
// input stalls until the first one is taken.
// Reset: width 640, height 480, counters at zero. The line store reads as
// zero until its columns are written (fill count), so no clearing pass.
// A register write over APB restarts the frame at row 0, column 0.
module sobel_gradient_magnitude_direction_top
  import sgmd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // pixel input
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] pixel
  // result output
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [79:0]       m_axis_tdata,   // grad_x, grad_y, magnitude,
                                            // direction, center_row,
                                            // center_col, zero pad (low first)
  output logic              m_axis_tlast    // frame_end
);

  state_e state_q, state_d;

  logic [WREG_W-1:0] width_q;
  logic [HREG_W-1:0] height_q;
  logic [WREG_W-1:0] w_eff;
  logic [HREG_W-1:0] h_eff;
  logic              cfg_wr;

  logic [COL_W-1:0]  col_q, col_d, cur_c_q;
  logic [ROW_W-1:0]  row_q, row_d, cur_r_q;
  logic [FILL_W-1:0] fill_q;
  logic [7:0]        px_q;
  logic              emit_q, last_q;
  logic              accept;

  logic [7:0]        win_q [9];
  logic [7:0]        top, mid;
  logic [LINE_W-1:0] rdata;
  logic              line_valid;

  logic signed [GRAD_W:0]   gx_w, gy_w;
  logic signed [GRAD_W-1:0] gx_q, gy_q;
  logic                     start, done;
  logic [MAG_W-1:0]         mag;
  logic signed [DIR_W-1:0]  dir;

  logic        out_free;
  logic        m_valid_q;
  logic [79:0] m_data_q;
  logic        m_last_q;

  // APB registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_HEIGHT) ? 32'(height_q) : 32'(width_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH) begin
        width_q <= pwdata[WREG_W-1:0];
      end else begin
        height_q <= pwdata[HREG_W-1:0];
      end
    end
  end

  // Clamp frame geometry
  always_comb begin
    w_eff = width_q;
    if (width_q < WREG_W'(3)) w_eff = WREG_W'(3);
    else if (width_q > WREG_W'(MAX_WIDTH)) w_eff = WREG_W'(MAX_WIDTH);
    h_eff = height_q;
    if (height_q < HREG_W'(3)) h_eff = HREG_W'(3);
    else if (height_q > HREG_W'(MAX_HEIGHT)) h_eff = HREG_W'(MAX_HEIGHT);
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Raster position of the next pixel
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_wr) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if ((WREG_W'(col_q) + 1'b1) >= w_eff) begin
        col_d = '0;
        row_d = ((HREG_W'(row_q) + 1'b1) >= h_eff) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Per-pixel context captured at transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q    <= s_axis_tdata;
      cur_c_q <= col_q;
      cur_r_q <= row_q;
      emit_q  <= (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
      last_q  <= (HREG_W'(row_q) == h_eff - 1'b1) && (WREG_W'(col_q) == w_eff - 1'b1);
    end
  end

  // Line store: read on transfer, write back in the following cycle
  sgmd_ram #(
    .Width(LINE_W),
    .Depth(MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_LOAD),
    .waddr_i (cur_c_q),
    .wdata_i ({mid, px_q}),
    .raddr_i (col_q),
    .rdata_o (rdata)
  );

  // Columns are always written in ascending order from zero, so the
  // written entries form a prefix tracked by a fill count.
  assign line_valid = {1'b0, cur_c_q} < fill_q;
  assign top        = line_valid ? rdata[15:8] : 8'd0;
  assign mid        = line_valid ? rdata[7:0]  : 8'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if ((state_q == ST_LOAD) && ({1'b0, cur_c_q} == fill_q)) begin
      fill_q <= fill_q + 1'b1;
    end
  end

  // Window shift and gradients from the shifted window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (state_q == ST_LOAD) begin
      win_q[0] <= win_q[1]; win_q[1] <= win_q[2]; win_q[2] <= top;
      win_q[3] <= win_q[4]; win_q[4] <= win_q[5]; win_q[5] <= mid;
      win_q[6] <= win_q[7]; win_q[7] <= win_q[8]; win_q[8] <= px_q;
    end
  end

  assign gx_w = ($signed({4'd0, top})        + $signed({3'd0, mid, 1'b0})
               + $signed({4'd0, px_q}))
              - ($signed({4'd0, win_q[1]})   + $signed({3'd0, win_q[4], 1'b0})
               + $signed({4'd0, win_q[7]}));
  assign gy_w = ($signed({4'd0, win_q[7]})   + $signed({3'd0, win_q[8], 1'b0})
               + $signed({4'd0, px_q}))
              - ($signed({4'd0, win_q[1]})   + $signed({3'd0, win_q[2], 1'b0})
               + $signed({4'd0, top}));

  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      gx_q <= gx_w[GRAD_W-1:0];
      gy_q <= gy_w[GRAD_W-1:0];
    end
  end

  // Start the engine in the cycle in which the registered gradients appear
  logic start_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
    end else begin
      start_q <= (state_q == ST_LOAD) && emit_q;
    end
  end
  assign start = start_q;

  sgmd_calc u_calc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .grad_x_i    (gx_q),
    .grad_y_i    (gy_q),
    .done_o      (done),
    .magnitude_o (mag),
    .direction_o (dir)
  );

  assign out_free = !m_valid_q || m_axis_tready;

  // Control: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_LOAD;
      ST_LOAD: state_d = emit_q ? ST_CALC : ST_IDLE;
      ST_CALC: if (done) state_d = ST_HOLD;
      ST_HOLD: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Control: output register load
  logic out_load;
  always_comb begin
    case (state_q)
      ST_HOLD: out_load = out_free;
      default: out_load = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {5'd0, cur_c_q - 1'b1, cur_r_q - 1'b1, dir, mag, gy_q, gx_q};
      m_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

endmodule

// File: rtl/core/sgmd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
module sgmd_ram #(
  parameter int Width = 16,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/sgmd_calc.sv
// Iterative magnitude (square root) and direction (CORDIC) engine.
module sgmd_calc
  import sgmd_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [GRAD_W-1:0] grad_x_i,
  input  logic signed [GRAD_W-1:0] grad_y_i,
  output logic                     done_o,
  output logic [MAG_W-1:0]         magnitude_o,
  output logic signed [DIR_W-1:0]  direction_o
);

  logic                     busy_q, busy_d;
  logic [STEP_W-1:0]        k_q, k_d;
  logic signed [CX_W-1:0]   x_q, x_d, y_q, y_d, xs, ys;
  logic signed [CZ_W-1:0]   z_q, z_d, ang;
  logic [SQ_W-1:0]          rem_q, rem_d, res_q, res_d, bit_v, trial;
  logic signed [13:0]       ax, ay;
  logic signed [21:0]       gx2, gy2;
  logic [22:0]              sum_sq;
  logic signed [CZ_W-1:0]   zr;
  logic signed [16:0]       t;
  logic [SQ_W-1:0]          mag_full;

  // Start values: fold left half-plane, scale by 2^16, squared sum for root
  assign ax     = (grad_x_i < 0) ? -14'(grad_x_i) : 14'(grad_x_i);
  assign ay     = (grad_x_i < 0) ? -14'(grad_y_i) : 14'(grad_y_i);
  assign gx2    = grad_x_i * grad_x_i;
  assign gy2    = grad_y_i * grad_y_i;
  assign sum_sq = 23'(unsigned'(gx2)) + 23'(unsigned'(gy2));

  // One CORDIC step and one root digit per cycle
  assign xs    = x_q >>> k_q;
  assign ys    = y_q >>> k_q;
  assign ang   = CZ_W'(atan_q16(k_q));
  assign bit_v = SQ_W'(1) << (5'd30 - {k_q, 1'b0});
  assign trial = res_q + bit_v;

  always_comb begin
    busy_d = busy_q;
    k_d    = k_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    rem_d  = rem_q;
    res_d  = res_q;
    if (start_i) begin
      busy_d = 1'b1;
      k_d    = '0;
      x_d    = {ax, 16'd0};
      y_d    = {ay, 16'd0};
      z_d    = (grad_x_i < 0) ? ((grad_y_i < 0) ? -PI_Q16 : PI_Q16) : '0;
      rem_d  = {sum_sq, 8'd0};
      res_d  = '0;
    end else if (busy_q) begin
      k_d = k_q + 1'b1;
      if (k_q == LAST_STEP) begin
        busy_d = 1'b0;
      end
      if (y_q > 0) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + ang;
      end else if (y_q < 0) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - ang;
      end
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        res_d = (res_q >> 1) + bit_v;
      end else begin
        res_d = res_q >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    y_q   <= y_d;
    z_q   <= z_d;
    rem_q <= rem_d;
    res_q <= res_d;
  end

  assign done_o = busy_q && (k_q == LAST_STEP);

  // Round to nearest: remainder above root means the upper integer is closer
  assign mag_full    = res_q + SQ_W'(rem_q > res_q);
  assign magnitude_o = mag_full[MAG_W-1:0];

  // Q16 to Q12 with rounding, then clamp to +-pi
  assign zr = (z_q + 21'sd8) >>> 4;
  assign t  = zr[16:0];
  always_comb begin
    if (t > DIR_LIMIT) begin
      direction_o = DIR_W'(DIR_LIMIT);
    end else if (t < -DIR_LIMIT) begin
      direction_o = DIR_W'(-DIR_LIMIT);
    end else begin
      direction_o = DIR_W'(t);
    end
  end

endmodule

// File: tb/tb_top.sv
// Testbench for the Sobel gradient block: directed frames, register extremes, random rasters.
module tb_top;
  import sgmd_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int SETTLE       = 40;     // idle wait after draining, longer than the input-to-result latency
  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 200;
  localparam int RANDOM_ITEMS = 256;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [MAG_W-1:0]         mag;
    logic signed [DIR_W-1:0]  dir;
    logic [ROW_W-1:0]         row;
    logic [COL_W-1:0]         col;
    logic                     last;
  } sobel_res_t;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata;   // [7:0] pixel
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [79:0]       m_axis_tdata;   // gx, gy, mag, dir, row, col, pad (low first)
  logic              m_axis_tlast;   // frame_end

  // predictor state
  logic [15:0]       line_mem [MAX_WIDTH];
  logic [7:0]        win [9];
  int                col_pos;
  int                row_pos;
  logic [WREG_W-1:0] width_reg;
  logic [HREG_W-1:0] height_reg;

  sobel_res_t        pending_q[$];
  int                err_cnt;
  int                pix_cnt;
  int                res_cnt;
  int                idle_cnt;
  int                hold_left;
  bit                quiet;

  sobel_gradient_magnitude_direction_top dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always begin
    clk_i = 1'b1; #HALF_PERIOD;
    clk_i = 1'b0; #HALF_PERIOD;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    err_cnt++;
    $display("MISMATCH %s: got %0d expected %0d", what, $signed(got), $signed(want));
  endtask

  // rounded integer square root
  function automatic int unsigned sqrt_round(input int unsigned v);
    int unsigned res, bitv, rem;
    res = 0; bitv = 32'h4000_0000; rem = v;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    if (v - res * res > res) res++;
    return res;
  endfunction

  // atan2 by 16-step CORDIC vectoring in Q16, rounded to Q12
  function automatic int angle_q12(input int gx, input int gy);
    longint x, y, z, xs, ys, t;
    longint tbl [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                         256, 128, 64, 32, 16, 8, 4, 2};
    x = longint'(gx); y = longint'(gy); z = 0;
    if (gx == 0 && gy == 0) return 0;
    if (gx < 0) begin
      x = -x; y = -y;
      z = (gy >= 0) ? longint'(205887) : longint'(-205887);
    end
    x = x * 65536; y = y * 65536;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i; ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += tbl[i];
      end else if (y < 0) begin
        x -= ys; y += xs; z -= tbl[i];
      end
    end
    t = (z + 8) >>> 4;
    if (t > 12868) t = 12868;
    if (t < -12868) t = -12868;
    return int'(t);
  endfunction

  // advance the raster by one pixel and queue the result it yields
  function automatic void push_pixel(input logic [7:0] px);
    int w, h, gx, gy;
    logic [7:0] top, mid;
    sobel_res_t r;
    w = int'(width_reg); h = int'(height_reg);
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < 3) h = 3;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    top = line_mem[col_pos][15:8];
    mid = line_mem[col_pos][7:0];
    line_mem[col_pos] = {mid, px};
    win[0] = win[1]; win[1] = win[2]; win[2] = top;
    win[3] = win[4]; win[4] = win[5]; win[5] = mid;
    win[6] = win[7]; win[7] = win[8]; win[8] = px;
    if (row_pos >= 2 && col_pos >= 2) begin
      gx = (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]))
         - (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]));
      gy = (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]))
         - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
      r.gx   = GRAD_W'(gx);
      r.gy   = GRAD_W'(gy);
      r.mag  = MAG_W'(sqrt_round(int'(gx * gx + gy * gy) * 256));
      r.dir  = DIR_W'(angle_q12(gx, gy));
      r.row  = ROW_W'(row_pos - 1);
      r.col  = COL_W'(col_pos - 1);
      r.last = (row_pos == h - 1 && col_pos == w - 1);
      pending_q.push_back(r);
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endfunction

  // one pixel transfer; tvalid is left high for a following item
  task automatic send_pixel(input logic [7:0] px);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    push_pixel(px);
    pix_cnt++;
  endtask

  // stop sending and wait for every expected result, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic reg_sel, input logic [31:0] val);
    logic [31:0] rd;
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (reg_sel == REG_WIDTH) width_reg = val[WREG_W-1:0];
    else height_reg = val[HREG_W-1:0];
    col_pos = 0; row_pos = 0;
    // read back
    @(negedge clk_i);
    penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rd = prdata;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
    if (reg_sel == REG_WIDTH && rd != 32'(width_reg))
      report("width readback", rd, 32'(width_reg));
    if (reg_sel == REG_HEIGHT && rd != 32'(height_reg))
      report("height readback", rd, 32'(height_reg));
  endtask

  task automatic set_frame(input int w, input int h);
    reg_write(REG_WIDTH, w);
    reg_write(REG_HEIGHT, h);
  endtask

  // one 3x3 frame from nine pixels, top row first
  task automatic send_tile(input logic [71:0] pix);
    for (int i = 8; i >= 0; i--) send_pixel(pix[i*8 +: 8]);
  endtask

  // receiver: random stalls, a forced hold-off, or always ready
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 26);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    sobel_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        report("unexpected result transfer", 32'd1, 32'd0);
      end else begin
        e = pending_q.pop_front();
        res_cnt++;
        if (m_axis_tdata[10:0] !== e.gx)
          report("grad_x", 32'(signed'(m_axis_tdata[10:0])), 32'(e.gx));
        if (m_axis_tdata[21:11] !== e.gy)
          report("grad_y", 32'(signed'(m_axis_tdata[21:11])), 32'(e.gy));
        if (m_axis_tdata[36:22] !== e.mag)
          report("magnitude", 32'(m_axis_tdata[36:22]), 32'(e.mag));
        if (m_axis_tdata[51:37] !== e.dir)
          report("direction", 32'(signed'(m_axis_tdata[51:37])), 32'(e.dir));
        if (m_axis_tdata[63:52] !== e.row)
          report("center_row", 32'(m_axis_tdata[63:52]), 32'(e.row));
        if (m_axis_tdata[74:64] !== e.col)
          report("center_col", 32'(m_axis_tdata[74:64]), 32'(e.col));
        if (m_axis_tlast !== e.last) report("frame_end", 32'(m_axis_tlast), 32'(e.last));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  // zero gradient, negative axis, strongest edges along -x, +x and -y, and a diagonal
  task automatic test_directed();
    set_frame(3, 3);
    send_tile(72'h00_00_00_00_00_00_00_00_00);
    send_tile(72'hFF_00_00_FF_00_00_FF_00_00);
    send_tile(72'h00_00_FF_00_00_FF_00_00_FF);
    send_tile(72'hFF_FF_FF_00_00_00_00_00_00);
    send_tile(72'hFF_FF_00_FF_00_00_00_00_00);
    drain();
  endtask

  // clamped widths and heights, and a restart in mid-frame
  task automatic test_register_limits();
    set_frame(0, 1);
    for (int i = 0; i < 12; i++) send_pixel(8'($urandom));
    drain();
    set_frame(5, 8191);
    for (int i = 0; i < 13; i++) send_pixel(8'($urandom));
    drain();
    reg_write(REG_WIDTH, 4);
    for (int i = 0; i < 14; i++) send_pixel(8'($urandom));
    drain();
  endtask

  // receiver holds off while pixels keep coming, so the input must stall
  task automatic test_backpressure();
    set_frame(3, 40);
    @(posedge clk_i);
    hold_left = HOLD_CYCLES;
    quiet = 1'b1;
    for (int i = 0; i < 60; i++) send_pixel(8'($urandom));
    quiet = 1'b0;
    drain();
  endtask

  // random small rasters, whole frames mostly, some cut short
  task automatic test_random();
    int w, h, n, sent;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      w = $urandom_range(3, 9);
      h = $urandom_range(3, 7);
      set_frame(w, h);
      n = ($urandom_range(9) == 0) ? $urandom_range(1, w * h) : w * h * $urandom_range(1, 2);
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      quiet = ($urandom_range(5) == 0);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(7))
          0:       send_pixel(8'h00);
          1:       send_pixel(8'hFF);
          default: send_pixel(8'($urandom));
        endcase
      end
      sent += n;
      quiet = 1'b0;
      drain();
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    err_cnt = 0; pix_cnt = 0; res_cnt = 0; idle_cnt = 0; hold_left = 0; quiet = 1'b0;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[i]) win[i] = '0;
    col_pos = 0; row_pos = 0;
    width_reg = WIDTH_RESET; height_reg = HEIGHT_RESET;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_register_limits();
    test_backpressure();
    test_random();

    drain();
    if (pending_q.size() != 0) begin
      report("results never arrived", 32'(pending_q.size()), 32'd0);
    end
    $display("covered: %0d pixels, %0d results, directed edges, clamped sizes, hold-off",
             pix_cnt, res_cnt);
    if (err_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
